// File: rtl/ookse_pkg.sv
`default_nettype none

package ookse_pkg;

  // Encodings of the bit_format register.
  localparam logic [1:0] FMT_HL  = 2'd0;
  localparam logic [1:0] FMT_LH  = 2'd1;
  localparam logic [1:0] FMT_RAW = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_FORMAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIMES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_TIMES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TIMES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TIMES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_BIT_TIME = 3'd5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned DUR_W = 16;

  // Fixed segment slots of one bit; a bit enables a subset of them.
  localparam int unsigned NUM_SLOTS = 7;
  localparam int unsigned SLOT_W    = 3;
  localparam logic [SLOT_W-1:0] SLOT_START_A = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_START_B = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_DATA_A  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_DATA_B  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_STOP_A  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_STOP_B  = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_HOLD    = 3'd6;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    logic [1:0]       bit_format;
    logic [31:0]      start_times;
    logic [31:0]      one_times;
    logic [31:0]      zero_times;
    logic [31:0]      stop_times;
    logic [DUR_W-1:0] raw_bit_time;
  } cfg_t;

  typedef struct packed {
    logic             pin_level;
    logic [DUR_W-1:0] duration_us;
    logic             last_segment;
  } seg_t;

endpackage

`default_nettype wire

// File: rtl/ookse_cfg_regs.sv
`default_nettype none

module ookse_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ookse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ookse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ookse_pkg::cfg_t                       cfg
);

  ookse_pkg::cfg_t cfg_r;

  // Register file, written one register at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ookse_pkg::REG_BIT_FORMAT:   cfg_r.bit_format   <= cfg_wdata[1:0];
        ookse_pkg::REG_START_TIMES:  cfg_r.start_times  <= cfg_wdata;
        ookse_pkg::REG_ONE_TIMES:    cfg_r.one_times    <= cfg_wdata;
        ookse_pkg::REG_ZERO_TIMES:   cfg_r.zero_times   <= cfg_wdata;
        ookse_pkg::REG_STOP_TIMES:   cfg_r.stop_times   <= cfg_wdata;
        ookse_pkg::REG_RAW_BIT_TIME:
          cfg_r.raw_bit_time <= cfg_wdata[ookse_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/ookse_slot_mask.sv
`default_nettype none

module ookse_slot_mask (
  input  wire ookse_pkg::cfg_t  cfg,
  input  wire logic             first_bit,
  input  wire logic             last_bit,
  output ookse_pkg::slot_mask_t mask
);

  logic pulsed;
  logic raw;

  assign pulsed = (cfg.bit_format == ookse_pkg::FMT_HL) ||
                  (cfg.bit_format == ookse_pkg::FMT_LH);
  assign raw    = (cfg.bit_format == ookse_pkg::FMT_RAW);

  // Pick the segments a bit produces; the unused format enables only the hold.
  always_comb begin
    mask = '0;
    mask[ookse_pkg::SLOT_START_A] = pulsed & first_bit;
    mask[ookse_pkg::SLOT_START_B] = pulsed & first_bit;
    mask[ookse_pkg::SLOT_DATA_A]  = pulsed | raw;
    mask[ookse_pkg::SLOT_DATA_B]  = pulsed;
    mask[ookse_pkg::SLOT_STOP_A]  = pulsed & last_bit;
    mask[ookse_pkg::SLOT_STOP_B]  = pulsed & last_bit;
    mask[ookse_pkg::SLOT_HOLD]    = last_bit;
  end

endmodule

`default_nettype wire

// File: rtl/ookse_seg_gen.sv
`default_nettype none

module ookse_seg_gen (
  input  wire ookse_pkg::cfg_t       cfg,
  input  wire logic                  data_bit,
  input  wire ookse_pkg::slot_mask_t rem,
  output ookse_pkg::slot_mask_t      rem_nxt,
  output ookse_pkg::seg_t            seg
);

  logic [ookse_pkg::SLOT_W-1:0] slot;
  logic [31:0]                  times;
  logic                         pair_level;

  // Lowest pending slot is the one sent now.
  always_comb begin
    slot = ookse_pkg::SLOT_HOLD;
    for (int i = ookse_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        slot = ookse_pkg::SLOT_W'(i);
      end
    end
  end

  assign rem_nxt = rem & (rem - ookse_pkg::slot_mask_t'(1));

  // Timing word of the pair this slot belongs to.
  always_comb begin
    case (slot)
      ookse_pkg::SLOT_START_A,
      ookse_pkg::SLOT_START_B: times = cfg.start_times;
      ookse_pkg::SLOT_STOP_A,
      ookse_pkg::SLOT_STOP_B:  times = cfg.stop_times;
      default:                 times = data_bit ? cfg.one_times : cfg.zero_times;
    endcase
  end

  // High-then-low sends high on the first slot of a pair, low-then-high on the second.
  assign pair_level = (cfg.bit_format == ookse_pkg::FMT_LH) ? slot[0] : ~slot[0];

  always_comb begin
    seg.last_segment = (rem_nxt == '0);
    if (slot == ookse_pkg::SLOT_HOLD) begin
      seg.pin_level   = 1'b0;
      seg.duration_us = '0;
    end else if (cfg.bit_format == ookse_pkg::FMT_RAW) begin
      seg.pin_level   = data_bit;
      seg.duration_us = cfg.raw_bit_time;
    end else begin
      seg.pin_level   = pair_level;
      seg.duration_us = pair_level ? times[31:16] : times[15:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ook_pulse_segment_encoder.sv
`default_nettype none

// OOK pulse segment encoder. Each accepted request (one frame bit with its
// first and last marks) expands into 1 to 7 (level, duration) segments on
// the output channel, one segment per clock while the output is not stalled;
// a typical data bit gives two segments, while a frame's first or last bit
// in a pulse format gives four to seven. The single output register sets
// that rate. One bit is held in an item register while its segments go
// out; the next request is accepted in the same cycle in which the held
// bit's final segment moves into the output register, so the block never
// sits idle between bits. A bit that produces no segment (unused format,
// not the last bit) is accepted and dropped. An accepted bit is loaded into the
// item register, then its segments move into the output register. The user
// must write configuration only while the block is idle; the block does not enforce it.
module ook_pulse_segment_encoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ookse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ookse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_data_bit,
  input  wire logic                             in_first_bit,
  input  wire logic                             in_last_bit,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_pin_level,
  output logic [ookse_pkg::DUR_W-1:0]           out_duration_us,
  output logic                                  out_last_segment
);

  ookse_pkg::cfg_t       cfg;
  ookse_pkg::slot_mask_t in_mask;
  ookse_pkg::slot_mask_t seg_rem_nxt;
  ookse_pkg::seg_t       seg;

  logic                  cur_valid_r, cur_valid_nxt;
  logic                  cur_bit_r;
  ookse_pkg::slot_mask_t cur_rem_r, cur_rem_nxt;
  logic                  out_valid_r;
  ookse_pkg::seg_t       out_seg_r;

  logic out_adv;
  logic emit;
  logic cur_done;
  logic in_accept;

  ookse_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ookse_slot_mask u_mask (
    .cfg       (cfg),
    .first_bit (in_first_bit),
    .last_bit  (in_last_bit),
    .mask      (in_mask)
  );

  ookse_seg_gen u_seg (
    .cfg      (cfg),
    .data_bit (cur_bit_r),
    .rem      (cur_rem_r),
    .rem_nxt  (seg_rem_nxt),
    .seg      (seg)
  );

  // Handshake control between the item register and the output register.
  assign out_adv   = !out_valid_r || !out_stall;
  assign emit      = cur_valid_r && out_adv;
  assign cur_done  = emit && seg.last_segment;
  assign in_stall  = cur_valid_r && !cur_done;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_rem_nxt   = cur_rem_r;
    if (in_accept) begin
      cur_valid_nxt = (in_mask != '0);
      cur_rem_nxt   = in_mask;
    end else if (emit) begin
      cur_valid_nxt = !cur_done;
      cur_rem_nxt   = seg_rem_nxt;
    end
  end

  // Item register: the bit being expanded and its pending slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_rem_r <= cur_rem_nxt;
    if (in_accept) begin
      cur_bit_r <= in_data_bit;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seg_r <= seg;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pin_level    = out_seg_r.pin_level;
  assign out_duration_us  = out_seg_r.duration_us;
  assign out_last_segment = out_seg_r.last_segment;

  // A held bit always has at least one segment left to send.
  a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_rem_r != '0))
    else $error("item register holds a bit with no pending segment");

  // Each emitted segment clears exactly one pending slot.
  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> ($countones(cur_rem_r) == $countones(seg_rem_nxt) + 1))
    else $error("segment step did not clear exactly one slot");

  // The final segment of a bit lands in the output register marked last.
  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    cur_done |=> (out_valid_r && out_seg_r.last_segment))
    else $error("final segment of a bit not marked last at the output");

  // An empty item register never pushes back on the input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !cur_valid_r |-> !in_stall)
    else $error("input stalled while no bit is held");

endmodule

`default_nettype wire
